// ----- hw/rtl/rhdc_pkg.sv -----
// Package for the record heapsort duplicate counter.
// Holds the capacity, derived widths and the record type; no dependencies.
package rhdc_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int KW = AW + 2;

  localparam int DEV_W = 64;
  localparam int INO_W = 64;
  localparam int IDX_W = 10;
  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] DRIFT_MAX = {CNT_W{1'b1}};

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;
  typedef logic [KW-1:0] kid_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [INO_W-1:0] inode;
    logic [IDX_W-1:0] index;
    logic             link;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ----- hw/rtl/rhdc_if.sv -----
// Valid/ready channel interfaces for records in and counts out.
// Depends on rhdc_pkg for field widths.
interface rhdc_rec_if;
  import rhdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEV_W-1:0] device_id;
  logic [INO_W-1:0] inode_number;
  logic [IDX_W-1:0] entry_index;
  logic             is_hard_link;
  logic             last_record;
  modport source (output valid, device_id, inode_number, entry_index, is_hard_link,
                  last_record, input ready);
  modport sink (input valid, device_id, inode_number, entry_index, is_hard_link,
                last_record, output ready);
endinterface

interface rhdc_res_if;
  import rhdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] drift_count;
  logic             overflowed;
  modport source (output valid, drift_count, overflowed, input ready);
  modport sink (input valid, drift_count, overflowed, output ready);
endinterface

// ----- hw/rtl/rhdc_ram.sv -----
// Generic RAM: one write port, two read ports with registered data.
// No dependencies.
module rhdc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- hw/rtl/rhdc_cmp.sv -----
// Shared key comparator: device, then inode, then entry index, ascending.
// Depends on rhdc_pkg for the record type.
module rhdc_cmp (
  input  rhdc_pkg::rec_t a,
  input  rhdc_pkg::rec_t b,
  output logic           precedes
);
  import rhdc_pkg::*;

  always_comb begin
    if (a.device != b.device) begin
      precedes = a.device < b.device;
    end else if (a.inode != b.inode) begin
      precedes = a.inode < b.inode;
    end else begin
      precedes = a.index < b.index;
    end
  end
endmodule

// ----- hw/rtl/record_heapsort_duplicate_count.sv -----
// Top level of the record heapsort duplicate counter.
// Depends on rhdc_pkg, rhdc_if, rhdc_ram and rhdc_cmp.
//
// Records are taken one per cycle while the block is idle and written to a
// single record RAM of MAX_RECORDS entries; records past capacity are dropped
// and flagged. A record with last_record set closes the batch: the block stops
// taking records, heap-sorts the RAM in place and then scans adjacent pairs,
// counting those with equal device and inode where neither is a hard link.
// One result transfer carries the count (saturating at 1023) and the overflow
// flag, after which the batch state clears and loading resumes. All work goes
// through the one RAM (two read ports, one write port) and one key comparator,
// so time is set by RAM accesses for loading and finishing each sift, for each
// level descended and for each scanned pair.
// Fewer than two records give a result the cycle after the last record.
// RAM contents are never cleared; only entries of the current batch are used.
module record_heapsort_duplicate_count (
  input logic      clk,
  input logic      rst,
  rhdc_rec_if.sink rec,
  rhdc_res_if.source res
);
  import rhdc_pkg::*;

  typedef enum logic [3:0] {
    IDLE, H_START, H_LOADED, H_KID, H_PICK, H_CMP, H_END,
    S_START, S_SWAP, C_READ, C_CHK, DONE
  } state_t;

  state_t           state;
  count_t           count;
  logic             ovf;
  count_t           n;
  count_t           bi;       // build loop counter, heap_down(bi-1, n)
  count_t           si;       // sort loop counter, swap(0, si) then sift
  count_t           sc;       // scan position
  addr_t            top;
  count_t           len;
  rec_t             hold;     // record being sifted down, written back at the end
  rec_t             pick_rec;
  addr_t            pick_addr;
  logic             build;
  logic [CNT_W-1:0] hits;

  // RAM and comparator hookup
  logic  we;
  addr_t waddr, raddr_a, raddr_b;
  rec_t  wdata;
  logic [REC_W-1:0] rd_a_raw, rd_b_raw;
  rec_t  rd_a, rd_b;
  rec_t  cmp_a, cmp_b;
  logic  precedes;

  kid_t  kid, kid1;
  logic  kid_ok, kid1_ok;
  logic  take, store;
  count_t n_new;
  logic  pair_hit;

  assign rd_a = rec_t'(rd_a_raw);
  assign rd_b = rec_t'(rd_b_raw);

  rhdc_ram #(.DEPTH(MAX_RECORDS), .WIDTH(REC_W), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a_raw),
    .rdata_b (rd_b_raw)
  );

  rhdc_cmp u_cmp (.a(cmp_a), .b(cmp_b), .precedes(precedes));

  assign rec.ready = (state == IDLE);
  assign take      = rec.valid && rec.ready;
  assign store     = take && (count < count_t'(MAX_RECORDS));
  assign n_new     = store ? count + count_t'(1) : count;

  assign res.valid       = (state == DONE);
  assign res.drift_count = hits;
  assign res.overflowed  = ovf;

  // Children of the current heap node
  assign kid     = {1'b0, top, 1'b1};
  assign kid1    = kid + kid_t'(1);
  assign kid_ok  = kid < kid_t'(len);
  assign kid1_ok = kid1 < kid_t'(len);

  assign pair_hit = (rd_a.device == rd_b.device) && (rd_a.inode == rd_b.inode) &&
                    !rd_a.link && !rd_b.link;

  always_comb begin
    we      = 1'b0;
    waddr   = top;
    wdata   = hold;
    raddr_a = '0;
    raddr_b = '0;
    cmp_a   = rd_a;
    cmp_b   = rd_b;
    case (state)
      IDLE: begin
        we    = store;
        waddr = addr_t'(count);
        wdata = '{device: rec.device_id, inode: rec.inode_number,
                  index: rec.entry_index, link: rec.is_hard_link};
      end
      H_START: raddr_a = addr_t'(bi - count_t'(1));
      H_KID: begin
        raddr_a = addr_t'(kid);
        raddr_b = addr_t'(kid1);
        we      = !kid_ok;        // leaf reached: drop the held record here
      end
      H_CMP: begin
        cmp_a = hold;
        cmp_b = pick_rec;
        we    = 1'b1;
        wdata = precedes ? pick_rec : hold;
      end
      S_START: begin
        raddr_a = '0;
        raddr_b = addr_t'(si);
      end
      S_SWAP: begin
        we    = 1'b1;             // old root goes to the tail
        waddr = addr_t'(si);
        wdata = rd_a;
      end
      C_READ: begin
        raddr_a = addr_t'(sc - count_t'(1));
        raddr_b = addr_t'(sc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      ovf   <= 1'b0;
      hits  <= '0;
      build <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (take) begin
            count <= n_new;
            if (!store) begin
              ovf <= 1'b1;
            end
            if (rec.last_record) begin
              n    <= n_new;
              hits <= '0;
              if (n_new < count_t'(2)) begin
                state <= DONE;
              end else begin
                bi    <= n_new >> 1;
                build <= 1'b1;
                state <= H_START;
              end
            end
          end
        end
        H_START: begin
          top   <= addr_t'(bi - count_t'(1));
          len   <= n;
          state <= H_LOADED;
        end
        H_LOADED: begin
          hold  <= rd_a;
          state <= H_KID;
        end
        H_KID: begin
          state <= kid_ok ? H_PICK : H_END;
        end
        H_PICK: begin
          // take the larger child; the right one only if it exists
          if (kid1_ok && precedes) begin
            pick_rec  <= rd_b;
            pick_addr <= addr_t'(kid1);
          end else begin
            pick_rec  <= rd_a;
            pick_addr <= addr_t'(kid);
          end
          state <= H_CMP;
        end
        H_CMP: begin
          if (precedes) begin
            top   <= pick_addr;
            state <= H_KID;
          end else begin
            state <= H_END;
          end
        end
        H_END: begin
          if (build) begin
            bi <= bi - count_t'(1);
            if (bi == count_t'(1)) begin
              build <= 1'b0;
              si    <= n - count_t'(1);
              state <= S_START;
            end else begin
              state <= H_START;
            end
          end else begin
            si <= si - count_t'(1);
            if (si == count_t'(1)) begin
              sc    <= count_t'(1);
              state <= C_READ;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_SWAP;
        end
        S_SWAP: begin
          hold  <= rd_b;
          top   <= '0;
          len   <= si;
          state <= H_KID;
        end
        C_READ: begin
          state <= C_CHK;
        end
        C_CHK: begin
          if (pair_hit && hits != DRIFT_MAX) begin
            hits <= hits + CNT_W'(1);
          end
          if (sc == n - count_t'(1)) begin
            state <= DONE;
          end else begin
            sc    <= sc + count_t'(1);
            state <= C_READ;
          end
        end
        DONE: begin
          if (res.ready) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Never take a record while a result is pending
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !rec.ready) else $error("record taken while result pending");

  // Fill count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(MAX_RECORDS)) else $error("record count beyond capacity");

  // Batch state clears after the result transfer
  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready) |=> (count == '0 && !ovf))
    else $error("batch state not cleared");

endmodule
